@@ rtl/core/tcdq_pkg.sv @@
// Shared types and constants for the timed change delay queue.
// Used by the queue cell, the cell chain and the top level; no dependencies.
package tcdq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int VALUE_BITS  = 32;
	localparam int TIME_BITS   = 48;
	localparam int DELAY_BITS  = 32;
	localparam int WORD_BITS   = 32;

	localparam logic [TIME_BITS-1:0]  TIME_MAX    = {TIME_BITS{1'b1}};
	localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(1000);

	// Request kinds carried in tuser
	localparam logic REQ_SAMPLE  = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [TIME_BITS-1:0]  time_t;

	// One queued change: due time and value, plus occupancy
	typedef struct packed {
		logic  valid;
		time_t due;
		val_t  val;
	} entry_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_SHIFT,
		CELL_SEED
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		time_t    new_due;
		val_t     new_val;
	} cell_ctl_t;

	// Fit a 32-bit port word into the stored value width
	function automatic val_t to_val(logic [WORD_BITS-1:0] x);
		logic [63:0] xe;
		xe = 64'(x);
		return xe[VALUE_BITS-1:0];
	endfunction

	// Bring a stored value back to the 32-bit port word
	function automatic logic [WORD_BITS-1:0] from_val(val_t v);
		logic [63:0] ve;
		ve = 64'(v);
		return ve[WORD_BITS-1:0];
	endfunction

endpackage

@@ rtl/core/tcdq_cell.sv @@
// One slot of the shifting change queue: holds a due time and a value.
// Depends on tcdq_pkg for the entry and command types.
module tcdq_cell import tcdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      first_cell,
	input  logic      left_valid,
	input  entry_t    right_ent,
	output entry_t    ent
);

	logic  valid_q;
	time_t due_q;
	val_t  val_q;
	logic  take_new;

	// A push lands in the first free slot, right behind the last occupied one
	assign take_new = (ctl.op == CELL_PUSH) && !valid_q && left_valid;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				CELL_HOLD: begin
				end
				CELL_PUSH: begin
					if (take_new) valid_q <= 1'b1;
				end
				CELL_SHIFT: begin
					valid_q <= right_ent.valid;
				end
				CELL_SEED: begin
					valid_q <= first_cell;
				end
			endcase
		end
	end

	// Payload: load new entry or advance toward the head
	always_ff @(posedge clk) begin
		if (take_new || ctl.op == CELL_SEED) begin
			due_q <= ctl.new_due;
			val_q <= ctl.new_val;
		end else if (ctl.op == CELL_SHIFT) begin
			due_q <= right_ent.due;
			val_q <= right_ent.val;
		end
	end

	assign ent = '{valid: valid_q, due: due_q, val: val_q};

endmodule

@@ rtl/core/tcdq_chain.sv @@
// Row of queue cells; cell 0 is the oldest entry, entries advance one slot per pop.
// Depends on tcdq_pkg and tcdq_cell.
module tcdq_chain import tcdq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	output entry_t    head,
	output logic      full
);

	entry_t cells [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   left_v;
		entry_t right_e;

		// Wire neighbors; the row ends are tied off
		if (i == 0) begin : g_first
			assign left_v = 1'b1;
		end else begin : g_mid
			assign left_v = cells[i-1].valid;
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cells[i+1];
		end

		tcdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.first_cell ((i == 0) ? 1'b1 : 1'b0),
			.left_valid (left_v),
			.right_ent  (right_e),
			.ent        (cells[i])
		);
	end

	assign head = cells[0];
	assign full = cells[QUEUE_DEPTH-1].valid;

endmodule

@@ rtl/core/timed_change_delay_queue.sv @@
// Timed change delay queue: control sequencer, output register and delay register.
// Depends on tcdq_pkg and tcdq_chain.
//
// Usage:
//   Input stream (s_axis_*): one transfer per sample or restart request.
//   tuser selects the kind (0 = sample, 1 = restart); tdata carries the time
//   stamp in ticks and the source value. Each request yields exactly one result
//   transfer on m_axis_*: changed flag, held output value and overflow flag.
//   A sample whose value differs from the newest queued one (or from the held
//   output when the queue is empty) is queued, if there is room, with due = now + delay_ticks,
//   saturated. Entries due strictly before now then leave the queue in order.
//   cfg_* writes delay_ticks; write it only while the block is idle.
// Sequence:
//   A sample goes through accept, queue update, one step per matured entry
//   plus a final check at the head cell, and result load. A restart goes
//   through accept, seed and result load. Matured entries leave one per cycle
//   by shifting the cell row. One request is in flight at a time.
// Reset:
//   arst_n empties the queue, clears the held output, sets delay_ticks to 1000.
// Back-pressure:
//   A result waits in the output register while m_axis_tready is low; the
//   next request is already accepted and held until that register frees up.
module timed_change_delay_queue import tcdq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // [47:0] now_time, [79:48] sample_value
	input  logic [0:0]  s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [0] changed, [32:1] out_value, [33] overflow
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic                  req_q;
	time_t                 now_q;
	val_t                  val_q;
	val_t                  held_q;
	val_t                  tail_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic                  changed_q;
	logic                  overflow_q;
	logic                  m_tvalid_q;
	logic [39:0]           m_tdata_q;

	cell_ctl_t    ctl;
	entry_t       head;
	logic         full;
	logic         differs;
	logic         mature;
	logic         out_free;
	logic [TIME_BITS:0] due_sum;
	time_t        due_sat;

	tcdq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (head),
		.full   (full)
	);

	// Compare against newest queued value, or held output when empty
	assign differs  = head.valid ? (tail_q != val_q) : (held_q != val_q);
	assign mature   = head.valid && (head.due < now_q);
	assign due_sum  = {1'b0, now_q} + (TIME_BITS+1)'(delay_q);
	assign due_sat  = due_sum[TIME_BITS] ? TIME_MAX : due_sum[TIME_BITS-1:0];
	assign out_free = !m_tvalid_q || m_axis_tready;

	// Drive the cell row
	always_comb begin
		ctl.op      = CELL_HOLD;
		ctl.new_due = (req_q == REQ_RESTART) ? now_q : due_sat;
		ctl.new_val = val_q;
		unique case (state_q)
			ST_PUSH: begin
				if (req_q == REQ_RESTART) ctl.op = CELL_SEED;
				else if (differs && !full) ctl.op = CELL_PUSH;
			end
			ST_POP: begin
				if (mature) ctl.op = CELL_SHIFT;
			end
			ST_IDLE, ST_DONE: begin
			end
		endcase
	end

	// Sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			held_q     <= '0;
			changed_q  <= 1'b0;
			overflow_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Load a new result or drop the one just transferred
			if (state_q == ST_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_axis_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					changed_q  <= 1'b0;
					overflow_q <= (req_q == REQ_SAMPLE) && differs && full;
					state_q    <= (req_q == REQ_RESTART) ? ST_DONE : ST_POP;
				end
				ST_POP: begin
					if (mature) begin
						held_q    <= head.val;
						changed_q <= 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, newest queued value and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			req_q <= s_axis_tuser[0];
			now_q <= s_axis_tdata[47:0];
			val_q <= to_val(s_axis_tdata[79:48]);
		end
		if (ctl.op == CELL_PUSH || ctl.op == CELL_SEED) tail_q <= val_q;
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {6'b0, overflow_q, from_val(held_q), changed_q};
		end
	end

	// Delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_valid) begin
			delay_q <= cfg_data;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign cfg_ready     = 1'b1;

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for timed_change_delay_queue: directed and random request streams.
// Depends on tcdq_pkg and the timed_change_delay_queue RTL; a tracker class predicts results.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcdq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 106;
	localparam int PRINT_CAP   = 40;

	// One expected result transfer
	typedef struct {
		bit        changed;
		bit [31:0] out_value;
		bit        overflow;
	} outcome_t;

	// Tracks the queue contents and the held output, and owes one result per request
	class delayed_value_tracker;
		bit [47:0]   due_at[QUEUE_DEPTH];
		bit [31:0]   value_at[QUEUE_DEPTH];
		int unsigned head;
		int unsigned count;
		bit [31:0]   held;
		bit [31:0]   delay;
		outcome_t    owed[$];
		int          errors;

		function new();
			head   = 0;
			count  = 0;
			held   = '0;
			delay  = DELAY_RESET;
			errors = 0;
		endfunction

		function void set_delay(bit [31:0] d);
			delay = d;
		endfunction

		// Apply one accepted request and queue the result it must produce
		function void note_request(bit kind, bit [47:0] now, bit [31:0] value);
			outcome_t    o;
			bit [48:0]   due_sum;
			bit          differs;
			int unsigned slot;
			o.changed  = 1'b0;
			o.overflow = 1'b0;
			if (kind == REQ_RESTART) begin
				head        = 0;
				due_at[0]   = now;
				value_at[0] = value;
				count       = 1;
			end else begin
				if (count > 0)
					differs = value_at[(head + count - 1) % QUEUE_DEPTH] != value;
				else
					differs = held != value;
				if (differs) begin
					if (count >= QUEUE_DEPTH) begin
						o.overflow = 1'b1;
					end else begin
						due_sum        = 49'(now) + 49'(delay);
						slot           = (head + count) % QUEUE_DEPTH;
						due_at[slot]   = due_sum[48] ? TIME_MAX : due_sum[47:0];
						value_at[slot] = value;
						count++;
					end
				end
				// Retire every front entry that is due strictly before now
				while (count > 0 && due_at[head] < now) begin
					held = value_at[head];
					head = (head + 1) % QUEUE_DEPTH;
					count--;
					o.changed = 1'b1;
				end
			end
			o.out_value = held;
			owed.push_back(o);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (errors < PRINT_CAP)
				$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
			errors++;
		endtask

		// Compare one result transfer with the oldest owed result
		task check_result(logic [39:0] word);
			outcome_t want;
			if (owed.size() == 0) begin
				report("unrequested result", word[31:0], '0);
				return;
			end
			want = owed.pop_front();
			if (word[0] !== want.changed)
				report("changed", 32'(word[0]), 32'(want.changed));
			if (word[32:1] !== want.out_value)
				report("out_value", word[32:1], want.out_value);
			if (word[33] !== want.overflow)
				report("overflow", 32'(word[33]), 32'(want.overflow));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;   // [47:0] now_time, [79:48] sample_value
	logic [0:0]  s_axis_tuser = '0;   // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [0] changed, [32:1] out_value, [33] overflow
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	bit          no_gaps = 1'b0;
	int          cycle_count = 0;

	delayed_value_tracker tracker = new();

	timed_change_delay_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		m_axis_tready = no_gaps || ($urandom_range(99) >= 24);
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata);
	end

	function automatic longint unsigned rand_upto(longint unsigned hi);
		return {$urandom, $urandom} % (hi + 1);
	endfunction

	// Offer one request, with random gaps, and wait for its transfer
	task automatic send_request(bit kind, longint unsigned now, bit [31:0] value);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 24) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {value, now[47:0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.note_request(kind, now[47:0], value);
	endtask

	// Drop valid and wait until every owed result has arrived
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (tracker.owed.size() != 0) @(posedge clk);
	endtask

	task automatic write_delay(bit [31:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_delay(d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		bit [31:0]       phase_delay[PHASE_COUNT];
		bit [31:0]       pool[4];
		bit [31:0]       last_value;
		bit [31:0]       value;
		bit              kind;
		longint unsigned tick_now;
		longint unsigned d;
		longint unsigned back;
		int              r;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset delay, strict maturity, queue fill, overflow, restart on full
		send_request(REQ_SAMPLE, 0, 32'h0000_0000);
		send_request(REQ_SAMPLE, 0, 32'hFFFF_FFFF);
		send_request(REQ_SAMPLE, 500, 32'hFFFF_FFFF);
		send_request(REQ_SAMPLE, 1000, 32'd5);
		send_request(REQ_SAMPLE, 1001, 32'd5);
		send_request(REQ_SAMPLE, 2500, 32'd5);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_request(REQ_SAMPLE, 3000, (i % 2) ? 32'h5A5A_5A5A : 32'hA5A5_A5A5);
		send_request(REQ_SAMPLE, 3000, 32'h3C3C_3C3C);
		send_request(REQ_RESTART, 3000, 32'd7);
		send_request(REQ_SAMPLE, TIME_MAX, 32'd7);
		drain_results();

		// Random phases, each under its own delay
		phase_delay = '{32'd0, 32'd1, 32'd17, 32'd1000, 32'($urandom_range(65535)),
			$urandom, 32'hFFFF_FFFF, 32'd5};
		last_value = 32'd7;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_delay(phase_delay[p]);
			d = phase_delay[p];
			no_gaps = (p == 3);
			for (int k = 0; k < 4; k++)
				pool[k] = (k == 0 && p % 2) ? 32'h0 : $urandom;
			// Start the last two phases close to the top of the time range
			if (p >= 6)
				tick_now = TIME_MAX - rand_upto(4 * d + 100);
			else
				tick_now = {$urandom_range(32767), $urandom};
			if ($urandom_range(1))
				send_request(REQ_RESTART, tick_now, last_value);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				kind = ($urandom_range(99) < 4) ? REQ_RESTART : REQ_SAMPLE;
				// Advance time: mostly short steps, some beyond the delay, a few backwards
				r = $urandom_range(99);
				if (r < 3) begin
					back = rand_upto(d / 2 + 1);
					tick_now = (tick_now > back) ? tick_now - back : 0;
				end else if (r < 60) begin
					tick_now += rand_upto((d >> 5) + 1);
				end else if (r < 88) begin
					tick_now += rand_upto(d + 2);
				end else begin
					tick_now += d + 1 + rand_upto(2 * d + 1);
				end
				if (tick_now > TIME_MAX)
					tick_now = TIME_MAX;
				// Repeat the value often so that changes come in bursts
				r = $urandom_range(99);
				if (r < 45)
					value = last_value;
				else if (r < 85)
					value = pool[$urandom_range(3)];
				else
					value = $urandom;
				last_value = value;
				send_request(kind, tick_now, value);
			end
			drain_results();
		end

		no_gaps = 1'b0;
		repeat (30) @(posedge clk);
		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/tcdq_pkg.sv
rtl/core/tcdq_cell.sv
rtl/core/tcdq_chain.sv
rtl/core/timed_change_delay_queue.sv
verif/tb_top.sv
